### rtl/core/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sorted table search block.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int KEY_W       = 64;
    localparam int POS_W       = 5;
    localparam int MAX_RESULTS = 32;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_I,
        ST_SORT_LD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_SRCH_ADDR,
        ST_SRCH_CMP,
        ST_ANSWER
    } state_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

    typedef struct packed {
        logic               kind;
        logic [KEY_W-1:0]   entry_key;
        logic               found;
        logic [POS_W-1:0]   position;
        logic               last;
    } res_t;

endpackage

### rtl/core/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/sts_cmp.sv
// ----------------------------------------------------------------------------
// sts_cmp
// Shared key comparator used by both the sort scan and the search probes.
// ----------------------------------------------------------------------------
module sts_cmp (
    input  logic [sts_pkg::KEY_W-1:0] a,
    input  logic [sts_pkg::KEY_W-1:0] b,
    output sts_pkg::cmp_res_t         res
);

    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule

### rtl/core/sts_seq.sv
// ----------------------------------------------------------------------------
// sts_seq
// Sequencer for load, selection sort, sorted emission and binary search.
// ----------------------------------------------------------------------------
module sts_seq #(
    parameter int DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [sts_pkg::KEY_W-1:0]     key,
    input  logic                          last_load,
    output logic                          ram_we,
    output logic [$clog2(DEPTH)-1:0]      ram_waddr,
    output logic [sts_pkg::KEY_W-1:0]     ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(DEPTH)-1:0]      ram_raddr,
    input  logic [sts_pkg::KEY_W-1:0]     ram_rdata,
    output logic [sts_pkg::KEY_W-1:0]     cmp_a,
    output logic [sts_pkg::KEY_W-1:0]     cmp_b,
    input  sts_pkg::cmp_res_t             cmp,
    output logic                          res_push,
    output sts_pkg::res_t                 res,
    input  logic                          res_ready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sts_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] best_reg, best_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [sts_pkg::KEY_W-1:0] lo_key_reg, lo_key_next;
    logic [sts_pkg::KEY_W-1:0] ikey_reg, ikey_next;
    logic [sts_pkg::KEY_W-1:0] key_reg, key_next;
    logic                      found_reg, found_next;
    logic [sts_pkg::POS_W-1:0] pos_reg, pos_next;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic          accept;
    logic          emit_last;

    // floor midpoint of lo and hi-1; only used while lo < hi
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, 1'b1};
    assign mid       = mid_sum[CW:1];
    assign accept    = in_valid && (state_reg == sts_pkg::ST_IDLE);
    assign emit_last = ((32'(i_reg) + 32'd1) == 32'(count_reg))
                    || ((32'(i_reg) + 32'd1) == 32'(sts_pkg::MAX_RESULTS));

    // one comparator: search probes against the searched key, sort scan
    // against the running minimum
    assign cmp_a = ram_rdata;
    assign cmp_b = (state_reg == sts_pkg::ST_SRCH_CMP) ? key_reg : lo_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sts_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        best_reg   <= best_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        lo_key_reg <= lo_key_next;
        ikey_reg   <= ikey_next;
        key_reg    <= key_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        best_next   = best_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        lo_key_next = lo_key_reg;
        ikey_next   = ikey_reg;
        key_next    = key_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;

        in_stall  = (state_reg != sts_pkg::ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = key;
        ram_re    = 1'b0;
        ram_raddr = i_reg[AW-1:0];
        res_push  = 1'b0;

        res.kind      = sts_pkg::KIND_ANSWER;
        res.entry_key = key_reg;
        res.found     = found_reg;
        res.position  = pos_reg;
        res.last      = 1'b1;

        unique case (state_reg)
            sts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == sts_pkg::MODE_LOAD)
                    begin
                        // drop the key once the table is full
                        if (32'(count_reg) < DEPTH)
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        if (last_load)
                        begin
                            i_next     = '0;
                            state_next = sts_pkg::ST_SORT_I;
                        end
                    end
                    else
                    begin
                        key_next   = key;
                        lo_next    = '0;
                        hi_next    = count_reg;
                        state_next = sts_pkg::ST_SRCH_ADDR;
                    end
                end
            end

            sts_pkg::ST_SORT_I:
            begin
                if ((32'(i_reg) + 32'd1) < 32'(count_reg))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = i_reg[AW-1:0];
                    state_next = sts_pkg::ST_SORT_LD;
                end
                else
                begin
                    i_next     = '0;
                    state_next = sts_pkg::ST_EMIT_RD;
                end
            end

            sts_pkg::ST_SORT_LD:
            begin
                lo_key_next = ram_rdata;
                ikey_next   = ram_rdata;
                best_next   = i_reg;
                j_next      = i_reg + CW'(1);
                state_next  = sts_pkg::ST_SORT_RD;
            end

            sts_pkg::ST_SORT_RD:
            begin
                if (j_reg < count_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = j_reg[AW-1:0];
                    state_next = sts_pkg::ST_SORT_CMP;
                end
                else
                begin
                    state_next = sts_pkg::ST_SWAP_A;
                end
            end

            sts_pkg::ST_SORT_CMP:
            begin
                if (cmp.lt)
                begin
                    lo_key_next = ram_rdata;
                    best_next   = j_reg;
                end
                j_next     = j_reg + CW'(1);
                state_next = sts_pkg::ST_SORT_RD;
            end

            sts_pkg::ST_SWAP_A:
            begin
                ram_we     = 1'b1;
                ram_waddr  = best_reg[AW-1:0];
                ram_wdata  = ikey_reg;
                state_next = sts_pkg::ST_SWAP_B;
            end

            sts_pkg::ST_SWAP_B:
            begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg[AW-1:0];
                ram_wdata  = lo_key_reg;
                i_next     = i_reg + CW'(1);
                state_next = sts_pkg::ST_SORT_I;
            end

            sts_pkg::ST_EMIT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = i_reg[AW-1:0];
                state_next = sts_pkg::ST_EMIT_OUT;
            end

            sts_pkg::ST_EMIT_OUT:
            begin
                res.kind      = sts_pkg::KIND_ENTRY;
                res.entry_key = ram_rdata;
                res.found     = 1'b0;
                res.position  = sts_pkg::POS_W'(i_reg);
                res.last      = emit_last;
                if (res_ready)
                begin
                    res_push = 1'b1;
                    if (emit_last)
                    begin
                        state_next = sts_pkg::ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = sts_pkg::ST_EMIT_RD;
                    end
                end
            end

            sts_pkg::ST_SRCH_ADDR:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = mid[AW-1:0];
                    mid_next   = mid;
                    state_next = sts_pkg::ST_SRCH_CMP;
                end
                else
                begin
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = sts_pkg::ST_ANSWER;
                end
            end

            sts_pkg::ST_SRCH_CMP:
            begin
                priority if (cmp.eq)
                begin
                    found_next = 1'b1;
                    pos_next   = sts_pkg::POS_W'(mid_reg);
                    state_next = sts_pkg::ST_ANSWER;
                end
                else if (cmp.lt)
                begin
                    lo_next    = mid_reg + CW'(1);
                    state_next = sts_pkg::ST_SRCH_ADDR;
                end
                else
                begin
                    hi_next    = mid_reg;
                    state_next = sts_pkg::ST_SRCH_ADDR;
                end
            end

            sts_pkg::ST_ANSWER:
            begin
                if (res_ready)
                begin
                    res_push   = 1'b1;
                    state_next = sts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/sorted_table_search.sv
// A load writes one entry while the table has room; a load marked last adds
// the selection sort, a read and a compare per scanned entry and two writes
// per pass, then emits the sorted entries one read each. A search takes up to
// ceil(log2(n+1)) probes for n entries, each a read and a compare. One item
// is in work at a time; the one RAM read port and comparator serve it all.
// Reset clears the entry count and the sequencer; the table needs no clearing.
// ----------------------------------------------------------------------------
// sorted_table_search
// Key table loaded one beat at a time, sorted in place by selection sort on
// the last load and searched by binary search. All compares share one unit.
// ----------------------------------------------------------------------------
module sorted_table_search #(
    parameter int DEPTH     = 32,
    parameter int KEY_BYTES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [sts_pkg::KEY_W-1:0]         key,
    input  logic                              last_load,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              kind,
    output logic [sts_pkg::KEY_W-1:0]         entry_key,
    output logic                              found,
    output logic [sts_pkg::POS_W-1:0]         position,
    output logic                              last
);

    localparam int AW = $clog2(DEPTH);
    // keep the top KEY_BYTES bytes, zero the rest
    localparam logic [sts_pkg::KEY_W-1:0] KEY_MASK =
        {sts_pkg::KEY_W{1'b1}} << (8 * (8 - KEY_BYTES));

    logic [sts_pkg::KEY_W-1:0] key_masked;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [sts_pkg::KEY_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [sts_pkg::KEY_W-1:0] ram_rdata;

    logic [sts_pkg::KEY_W-1:0] cmp_a;
    logic [sts_pkg::KEY_W-1:0] cmp_b;
    sts_pkg::cmp_res_t         cmp;

    logic                      res_push;
    logic                      res_ready;
    sts_pkg::res_t             res;

    logic                      out_valid_reg, out_valid_next;
    sts_pkg::res_t             res_reg;

    assign key_masked = key & KEY_MASK;

    // key storage: one write and one registered read per cycle
    sts_ram #(
        .WIDTH (sts_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // the one comparator shared by sort scan and search probes
    sts_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp)
    );

    sts_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .key       (key_masked),
        .last_load (last_load),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .cmp_a     (cmp_a),
        .cmp_b     (cmp_b),
        .cmp       (cmp),
        .res_push  (res_push),
        .res       (res),
        .res_ready (res_ready)
    );

    // output register: take a new result beat when empty or draining
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the payload while the beat is stalled
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = res_reg.kind;
    assign entry_key = res_reg.entry_key;
    assign found     = res_reg.found;
    assign position  = res_reg.position;
    assign last      = res_reg.last;

endmodule

### sim/sorted_table_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_search_checker
// Watches both channels of the sorted table search block. It keeps its own
// copy of the key table, works out the sorted entries and search answers for
// every input beat, and compares each result beat with the oldest one due.
// ----------------------------------------------------------------------------
module sorted_table_search_checker
    import sts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              mode,
    input  logic [KEY_W-1:0]  key,
    input  logic              last_load,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              kind,
    input  logic [KEY_W-1:0]  entry_key,
    input  logic              found,
    input  logic [POS_W-1:0]  position,
    input  logic              last,
    output int                fail_count,
    output int                pending,
    output int                checked
);

    localparam int DEPTH     = 32;
    localparam int KEY_BYTES = 8;
    localparam logic [KEY_W-1:0] KEY_MASK = ~64'd0 << (8 * (8 - KEY_BYTES));

    logic [KEY_W-1:0] table_keys [DEPTH];
    int               entries = 0;
    res_t             due_results [$];

    function automatic res_t make_result(logic k, logic [KEY_W-1:0] ek, logic f,
                                         int pos, logic l);
        res_t r;
        r.kind      = k;
        r.entry_key = ek;
        r.found     = f;
        r.position  = pos[POS_W-1:0];
        r.last      = l;
        return r;
    endfunction

    // Selection sort in place, ascending as unsigned numbers.
    task automatic sort_entries();
        int               i;
        int               j;
        int               best;
        logic [KEY_W-1:0] lowest;
        for (i = 0; i + 1 < entries; i++)
        begin
            best   = i;
            lowest = table_keys[i];
            for (j = i + 1; j < entries; j++)
            begin
                if (table_keys[j] < lowest)
                begin
                    lowest = table_keys[j];
                    best   = j;
                end
            end
            table_keys[best] = table_keys[i];
            table_keys[i]    = lowest;
        end
    endtask

    task automatic predict_beat(logic m, logic [KEY_W-1:0] raw, logic fin);
        logic [KEY_W-1:0] k;
        int               lo;
        int               hi;
        int               mid;
        int               n;
        int               i;
        bit               hit;
        k = raw & KEY_MASK;
        if (m == MODE_LOAD)
        begin
            // Drop the key once the table is full.
            if (entries < DEPTH)
            begin
                table_keys[entries] = k;
                entries++;
            end
            if (fin)
            begin
                sort_entries();
                n = (entries < MAX_RESULTS) ? entries : MAX_RESULTS;
                for (i = 0; i < n; i++)
                    due_results.push_back(make_result(KIND_ENTRY, table_keys[i], 1'b0,
                                                      i, i + 1 == n));
            end
        end
        else
        begin
            // Binary search over the table as it stands, floor midpoint.
            lo  = 0;
            hi  = entries - 1;
            mid = 0;
            hit = 1'b0;
            while (!hit && lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (table_keys[mid] == k)
                    hit = 1'b1;
                else if (table_keys[mid] > k)
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
            due_results.push_back(make_result(KIND_ANSWER, k, hit, hit ? mid : 0, 1'b1));
        end
    endtask

    task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            entries    = 0;
            fail_count = 0;
            checked    = 0;
            due_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing due: kind %0d key %0h", kind, entry_key);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("entry_key", want.entry_key, entry_key);
                    check_field("found", want.found, found);
                    check_field("position", want.position, position);
                    check_field("last", want.last, last);
                    checked++;
                end
            end
            if (in_valid && !in_stall)
                predict_beat(mode, key, last_load);
        end
        pending = due_results.size();
    end

endmodule

### sim/sorted_table_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_search_test
// Drives load and search beats into the sorted table search block, with
// random gaps and result stalls, and lets the checker beside the block judge
// every result. Directed beats cover empty, unsorted, duplicate and full
// tables; random beats then fill and probe the table.
// ----------------------------------------------------------------------------
module sorted_table_search_test;

    import sts_pkg::*;

    localparam int DEPTH         = 32;
    localparam int RANDOM_BEATS  = 300;
    localparam int QUIET_BEATS   = 40;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 50;
    // A full sort runs with no beat moving; allow plenty.
    localparam int QUIET_LIMIT   = 20000;

    // Short text keys, first character in the top byte, NUL padded.
    localparam logic [KEY_W-1:0] TXT_ALPHA   = 64'h616C_7068_6100_0000;
    localparam logic [KEY_W-1:0] TXT_BRAVO   = 64'h6272_6176_6F00_0000;
    localparam logic [KEY_W-1:0] TXT_CHARLIE = 64'h6368_6172_6C69_6500;
    localparam logic [KEY_W-1:0] TXT_DELTA   = 64'h6465_6C74_6100_0000;
    localparam logic [KEY_W-1:0] TXT_ECHO    = 64'h6563_686F_0000_0000;
    localparam logic [KEY_W-1:0] KEY_ZERO    = 64'h0;
    localparam logic [KEY_W-1:0] KEY_ONES    = ~64'h0;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              mode;
    logic [KEY_W-1:0]  key;
    logic              last_load;
    logic              out_valid;
    logic              out_stall;
    logic              kind;
    logic [KEY_W-1:0]  entry_key;
    logic              found;
    logic [POS_W-1:0]  position;
    logic              last;

    int fail_count;
    int pending;
    int checked;

    // Stimulus side bookkeeping: keys that went into the table, for picking
    // search keys that hit.
    logic [KEY_W-1:0] stored_keys [$];
    int  load_beats   = 0;
    int  sort_beats   = 0;
    int  search_beats = 0;
    int  quiet_cycles = 0;
    bit  hold_off_req = 1'b0;
    bit  quiet_tail   = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_table_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .key       (key),
        .last_load (last_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .entry_key (entry_key),
        .found     (found),
        .position  (position),
        .last      (last)
    );

    sorted_table_search_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .key        (key),
        .last_load  (last_load),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .entry_key  (entry_key),
        .found      (found),
        .position   (position),
        .last       (last),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // Offer one beat at the current falling edge, hold it until accepted,
    // then advance to the next falling edge.
    task automatic offer_beat(logic m, logic [KEY_W-1:0] k, logic fin);
        mode      <= m;
        key       <= k;
        last_load <= fin;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (m == MODE_LOAD)
        begin
            load_beats++;
            if (fin)
                sort_beats++;
            if (stored_keys.size() < DEPTH)
                stored_keys.push_back(k);
        end
        else
            search_beats++;
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles)
            @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] random_text();
        logic [KEY_W-1:0] k;
        int               len;
        int               b;
        k   = '0;
        len = $urandom_range(1, 8);
        for (b = 0; b < 8; b++)
            k = {k[KEY_W-9:0], (b < len) ? 8'($urandom_range(8'h61, 8'h7A)) : 8'h00};
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // Keys in the table, keys right beside one, and arbitrary text or raw
    // words, in about equal shares.
    function automatic logic [KEY_W-1:0] pick_search_key();
        logic [KEY_W-1:0] k;
        int               roll;
        roll = $urandom_range(0, 99);
        if (stored_keys.size() == 0 || roll >= 65)
            k = (roll >= 85) ? random_word() : random_text();
        else
        begin
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            if (roll >= 50)
                k = k + 64'd1;
            else if (roll >= 35)
                k = k - 64'd1;
        end
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] pick_load_key();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2 && stored_keys.size() != 0)
            return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (roll < 4)
            return random_word();
        return random_text();
    endfunction

    // Receiver: random stall bursts, free stretches, and one long hold-off
    // on request. Drive out_stall once per falling edge at most.
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                hold_off_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4))
                    @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 6))
                    @(negedge clk);
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
                $display("** sorted_table_search: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int  i;
        bit  is_load;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = MODE_LOAD;
        key       = '0;
        last_load = 1'b0;
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Search before anything is loaded: both must miss.
        offer_beat(MODE_SEARCH, KEY_ZERO, 1'b0);
        offer_beat(MODE_SEARCH, KEY_ONES, 1'b1);
        // Load out of order, with both extremes and a duplicate.
        offer_beat(MODE_LOAD, TXT_DELTA, 1'b0);
        offer_beat(MODE_LOAD, KEY_ONES, 1'b0);
        offer_beat(MODE_LOAD, KEY_ZERO, 1'b0);
        offer_beat(MODE_LOAD, TXT_ALPHA, 1'b0);
        offer_beat(MODE_LOAD, TXT_DELTA, 1'b0);
        // Search the table before it is sorted.
        offer_beat(MODE_SEARCH, TXT_ALPHA, 1'b0);
        offer_beat(MODE_SEARCH, KEY_ZERO, 1'b1);
        // Final load: sort and emit six entries.
        offer_beat(MODE_LOAD, TXT_CHARLIE, 1'b1);
        offer_beat(MODE_SEARCH, KEY_ZERO, 1'b0);
        offer_beat(MODE_SEARCH, KEY_ONES, 1'b0);
        offer_beat(MODE_SEARCH, TXT_DELTA, 1'b0);
        offer_beat(MODE_SEARCH, TXT_CHARLIE, 1'b0);
        offer_beat(MODE_SEARCH, TXT_BRAVO, 1'b0);
        offer_beat(MODE_SEARCH, 64'h1, 1'b0);
        offer_beat(MODE_SEARCH, ~64'h1, 1'b0);
        // Append one more, leaving the table unsorted again.
        offer_beat(MODE_LOAD, TXT_ECHO, 1'b0);
        offer_beat(MODE_SEARCH, TXT_ECHO, 1'b0);

        for (i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == RANDOM_BEATS - QUIET_BEATS)
                quiet_tail = 1'b1;
            // Hold the result side for a long stretch and keep offering
            // searches so the block backs up into its input.
            if (i == 90)
                hold_off_req = 1'b1;
            // Pause the sender until every result due has come back.
            if (i == 180)
            begin
                in_valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            if (!quiet_tail && $urandom_range(0, 4) == 0)
                idle_sender($urandom_range(1, 4));
            is_load = (i < 90 || i >= 102) && $urandom_range(0, 99) < 20;
            if (is_load)
                offer_beat(MODE_LOAD, pick_load_key(), $urandom_range(0, 9) < 3);
            else
                offer_beat(MODE_SEARCH, pick_search_key(), 1'($urandom_range(0, 1)));
        end

        // Fill the table, then load past full: the last one still sorts and
        // emits the whole table.
        while (stored_keys.size() < DEPTH)
            offer_beat(MODE_LOAD, random_text(), 1'b0);
        offer_beat(MODE_LOAD, random_word(), 1'b0);
        offer_beat(MODE_LOAD, random_word(), 1'b1);
        offer_beat(MODE_SEARCH, stored_keys[0], 1'b0);
        offer_beat(MODE_SEARCH, stored_keys[DEPTH-1], 1'b0);

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("covered %0d loads (%0d with a sort) and %0d searches,",
                 load_beats, sort_beats, search_beats);
        $display("from empty through unsorted to full tables; %0d result beats compared",
                 checked);
        if (fail_count == 0 && pending == 0)
            $display("** sorted_table_search: PASSED **");
        else
            $display("** sorted_table_search: FAILED **");
        $finish;
    end

endmodule
